>>> rtl/core/tse_pkg.sv
package tse_pkg;

   localparam int unsigned STEP_W    = 5;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 32;
   localparam int unsigned FREQ_W    = 32;
   localparam int unsigned CODE_W    = 8;
   localparam int unsigned TIME_W    = 64;
   localparam int unsigned STATUS_W  = 3;
   localparam int unsigned DIV_CNT_W = 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FREQ       = 2'd0,
      CSR_CMD_SET    = 2'd1,
      CSR_CMD_ID     = 2'd2,
      CSR_COMPLETION = 2'd3
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_SENT           = 3'd0,
      ST_SENT_PENDING   = 3'd1,
      ST_ACCEPTED       = 3'd2,
      ST_TRANSPORT_FAIL = 3'd3,
      ST_BAD_HEADER     = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      OP_LOAD,
      OP_NOP,
      OP_ELAPSED,
      OP_MUL_A,
      OP_MUL_B,
      OP_MUL_C,
      OP_DIV_INIT,
      OP_DIV_ITER,
      OP_ADD,
      OP_NTP_A,
      OP_NTP_B,
      OP_NTP_C,
      OP_NTP_D,
      OP_NTP_E,
      OP_OUT_ACC,
      OP_OUT_REQ,
      OP_OUT_FAIL
   } op_type;

   typedef enum logic [1:0] {
      WAIT_NONE,
      WAIT_REQ,
      WAIT_RSP
   } wait_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_BAD_RESP,
      COND_FREQ_ZERO,
      COND_IS_REQ,
      COND_DIV_MORE
   } cond_type;

   typedef struct packed {
      op_type             op;
      wait_type           wt;
      cond_type           cond;
      logic [STEP_W-1:0]  target;
   } ctrl_word_type;

   typedef struct packed {
      logic is_req;
      logic bad_resp;
      logic freq_zero;
      logic div_more;
      logic out_free;
   } dp_flags_type;

   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic [CODE_W-1:0] cmd_set;
      logic [CODE_W-1:0] cmd_id;
      logic [CODE_W-1:0] completion;
   } cfg_type;

   localparam logic [STEP_W-1:0] S_IDLE     = 5'd0;
   localparam logic [STEP_W-1:0] S_CHECK    = 5'd1;
   localparam logic [STEP_W-1:0] S_ELAPSED  = 5'd2;
   localparam logic [STEP_W-1:0] S_MUL_A    = 5'd3;
   localparam logic [STEP_W-1:0] S_MUL_B    = 5'd4;
   localparam logic [STEP_W-1:0] S_MUL_C    = 5'd5;
   localparam logic [STEP_W-1:0] S_DIV_INIT = 5'd6;
   localparam logic [STEP_W-1:0] S_DIV_ITER = 5'd7;
   localparam logic [STEP_W-1:0] S_ADD      = 5'd8;
   localparam logic [STEP_W-1:0] S_NTP_A    = 5'd9;
   localparam logic [STEP_W-1:0] S_NTP_B    = 5'd10;
   localparam logic [STEP_W-1:0] S_NTP_C    = 5'd11;
   localparam logic [STEP_W-1:0] S_NTP_D    = 5'd12;
   localparam logic [STEP_W-1:0] S_NTP_E    = 5'd13;
   localparam logic [STEP_W-1:0] S_OUT_ACC  = 5'd14;
   localparam logic [STEP_W-1:0] S_OUT_REQ  = 5'd15;
   localparam logic [STEP_W-1:0] S_OUT_FAIL = 5'd16;
   localparam logic [STEP_W-1:0] S_LAST     = S_OUT_FAIL;

   function automatic ctrl_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ctrl_word_type cw;
      unique case (step)
         S_IDLE:     cw = '{OP_LOAD,     WAIT_REQ,  COND_NEVER,     S_IDLE};
         S_CHECK:    cw = '{OP_NOP,      WAIT_NONE, COND_BAD_RESP,  S_OUT_FAIL};
         S_ELAPSED:  cw = '{OP_ELAPSED,  WAIT_NONE, COND_FREQ_ZERO, S_ADD};
         S_MUL_A:    cw = '{OP_MUL_A,    WAIT_NONE, COND_NEVER,     S_IDLE};
         S_MUL_B:    cw = '{OP_MUL_B,    WAIT_NONE, COND_NEVER,     S_IDLE};
         S_MUL_C:    cw = '{OP_MUL_C,    WAIT_NONE, COND_NEVER,     S_IDLE};
         S_DIV_INIT: cw = '{OP_DIV_INIT, WAIT_NONE, COND_NEVER,     S_IDLE};
         S_DIV_ITER: cw = '{OP_DIV_ITER, WAIT_NONE, COND_DIV_MORE,  S_DIV_ITER};
         S_ADD:      cw = '{OP_ADD,      WAIT_NONE, COND_IS_REQ,    S_OUT_REQ};
         S_NTP_A:    cw = '{OP_NTP_A,    WAIT_NONE, COND_NEVER,     S_IDLE};
         S_NTP_B:    cw = '{OP_NTP_B,    WAIT_NONE, COND_NEVER,     S_IDLE};
         S_NTP_C:    cw = '{OP_NTP_C,    WAIT_NONE, COND_NEVER,     S_IDLE};
         S_NTP_D:    cw = '{OP_NTP_D,    WAIT_NONE, COND_NEVER,     S_IDLE};
         S_NTP_E:    cw = '{OP_NTP_E,    WAIT_NONE, COND_NEVER,     S_IDLE};
         S_OUT_ACC:  cw = '{OP_OUT_ACC,  WAIT_RSP,  COND_ALWAYS,    S_IDLE};
         S_OUT_REQ:  cw = '{OP_OUT_REQ,  WAIT_RSP,  COND_ALWAYS,    S_IDLE};
         S_OUT_FAIL: cw = '{OP_OUT_FAIL, WAIT_RSP,  COND_ALWAYS,    S_IDLE};
         default:    cw = '{OP_NOP,      WAIT_NONE, COND_ALWAYS,    S_IDLE};
      endcase
      return cw;
   endfunction

endpackage

>>> rtl/core/tse_seq.sv
module tse_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_accept,
   input  tse_pkg::dp_flags_type flags,
   output tse_pkg::ctrl_word_type ctrl
);
   import tse_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              hold;
   logic              taken;

   assign ctrl = ucode_rom(step_ff);

   always_comb begin
      hold = ((ctrl.wt == WAIT_REQ) && !req_accept) ||
             ((ctrl.wt == WAIT_RSP) && !flags.out_free);
      unique case (ctrl.cond)
         COND_NEVER:     taken = 1'b0;
         COND_ALWAYS:    taken = 1'b1;
         COND_BAD_RESP:  taken = flags.bad_resp;
         COND_FREQ_ZERO: taken = flags.freq_zero;
         COND_IS_REQ:    taken = flags.is_req;
         COND_DIV_MORE:  taken = flags.div_more;
         default:        taken = 1'b1;
      endcase
      if (hold) begin
         step_in = step_ff;
      end else if (taken) begin
         step_in = ctrl.target;
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

`ifndef SYNTHESIS
   a_step_in_program: assert property (@(posedge clock) disable iff (reset)
      step_ff <= S_LAST)
      else $error("sequencer stepped outside the program");
`endif

endmodule

>>> rtl/core/tse_dp.sv
module tse_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  tse_pkg::ctrl_word_type              ctrl,
   input  tse_pkg::cfg_type                    cfg,
   input  logic                                req_accept,
   input  logic                                req_command,
   input  logic [tse_pkg::TIME_W-1:0]          req_counter_now,
   input  logic                                req_transport_ok,
   input  logic [tse_pkg::CODE_W-1:0]          req_resp_command_set,
   input  logic [tse_pkg::CODE_W-1:0]          req_resp_command_id,
   input  logic [tse_pkg::CODE_W-1:0]          req_resp_completion,
   input  logic [tse_pkg::TIME_W-1:0]          req_echoed_send_time,
   input  logic [tse_pkg::TIME_W-1:0]          req_partner_receive_time,
   input  logic [tse_pkg::TIME_W-1:0]          req_partner_reply_time,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [tse_pkg::STATUS_W-1:0]        rsp_status,
   output logic [tse_pkg::TIME_W-1:0]          rsp_time_ms,
   output logic [tse_pkg::TIME_W-1:0]          rsp_sync_counter,
   output tse_pkg::dp_flags_type               flags
);
   import tse_pkg::*;

   logic                  cmd_ff, cmd_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic                  tok_ff, tok_in;
   logic [CODE_W-1:0]     cset_ff, cset_in;
   logic [CODE_W-1:0]     cid_ff, cid_in;
   logic [CODE_W-1:0]     comp_ff, comp_in;
   logic [TIME_W-1:0]     t0_ff, t0_in;
   logic [TIME_W-1:0]     t1_ff, t1_in;
   logic [TIME_W-1:0]     t2_ff, t2_in;
   logic [TIME_W-1:0]     acc_ff, acc_in;
   logic [TIME_W-1:0]     x_ff, x_in;
   logic [FREQ_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [TIME_W-1:0]     ref_time_ff, ref_time_in;
   logic [TIME_W-1:0]     ref_cnt_ff, ref_cnt_in;
   logic                  pending_ff, pending_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [TIME_W-1:0]     rsp_time_ff, rsp_time_in;
   logic [TIME_W-1:0]     rsp_sync_ff, rsp_sync_in;

   logic                  out_free;
   logic                  hdr_ok;
   logic [FREQ_W:0]       shifted;
   logic                  quo_bit;
   logic [TIME_W-1:0]     rounded;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign hdr_ok   = (cset_ff == cfg.cmd_set) && (cid_ff == cfg.cmd_id) &&
                     (comp_ff == cfg.completion);
   assign shifted  = {rem_ff, x_ff[TIME_W-1]};
   assign quo_bit  = shifted >= {1'b0, cfg.freq};
   assign rounded  = x_ff + {{(TIME_W-1){1'b0}}, x_ff[TIME_W-1]};

   assign flags.is_req    = !cmd_ff;
   assign flags.bad_resp  = cmd_ff && (!tok_ff || !hdr_ok);
   assign flags.freq_zero = cfg.freq == '0;
   assign flags.div_more  = cnt_ff != '0;
   assign flags.out_free  = out_free;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_time_ms      = rsp_time_ff;
   assign rsp_sync_counter = rsp_sync_ff;

   always_comb begin
      cmd_in        = cmd_ff;
      now_in        = now_ff;
      tok_in        = tok_ff;
      cset_in       = cset_ff;
      cid_in        = cid_ff;
      comp_in       = comp_ff;
      t0_in         = t0_ff;
      t1_in         = t1_ff;
      t2_in         = t2_ff;
      acc_in        = acc_ff;
      x_in          = x_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      ref_time_in   = ref_time_ff;
      ref_cnt_in    = ref_cnt_ff;
      pending_in    = pending_ff;
      rsp_status_in = rsp_status_ff;
      rsp_time_in   = rsp_time_ff;
      rsp_sync_in   = rsp_sync_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      unique case (ctrl.op)
         OP_LOAD: begin
            if (req_accept) begin
               cmd_in  = req_command;
               now_in  = req_counter_now;
               tok_in  = req_transport_ok;
               cset_in = req_resp_command_set;
               cid_in  = req_resp_command_id;
               comp_in = req_resp_completion;
               t0_in   = req_echoed_send_time;
               t1_in   = req_partner_receive_time;
               t2_in   = req_partner_reply_time;
            end
         end
         OP_NOP: begin
         end
         OP_ELAPSED:  acc_in = now_ff - ref_cnt_ff;
         OP_MUL_A:    x_in = {acc_ff[TIME_W-11:0], 10'b0};
         OP_MUL_B:    x_in = x_ff - {acc_ff[TIME_W-5:0], 4'b0};
         OP_MUL_C:    x_in = x_ff - {acc_ff[TIME_W-4:0], 3'b0};
         OP_DIV_INIT: begin
            rem_in = '0;
            cnt_in = '1;
         end
         OP_DIV_ITER: begin
            rem_in = quo_bit ? FREQ_W'(shifted - {1'b0, cfg.freq}) : shifted[FREQ_W-1:0];
            x_in   = {x_ff[TIME_W-2:0], quo_bit};
            cnt_in = cnt_ff - 1'b1;
         end
         OP_ADD:      acc_in = ref_time_ff + (flags.freq_zero ? '0 : x_ff);
         OP_NTP_A:    x_in = t1_ff - t0_ff;
         OP_NTP_B:    x_in = x_ff + t2_ff;
         OP_NTP_C:    x_in = x_ff - acc_ff;
         OP_NTP_D:    x_in = {rounded[TIME_W-1], rounded[TIME_W-1:1]};
         OP_NTP_E:    acc_in = acc_ff + x_ff;
         OP_OUT_ACC: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_ACCEPTED;
               rsp_time_in   = acc_ff;
               rsp_sync_in   = now_ff;
               ref_time_in   = acc_ff;
               ref_cnt_in    = now_ff;
               pending_in    = 1'b0;
            end
         end
         OP_OUT_REQ: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pending_ff ? ST_SENT_PENDING : ST_SENT;
               rsp_time_in   = acc_ff;
               rsp_sync_in   = '0;
               pending_in    = 1'b1;
            end
         end
         OP_OUT_FAIL: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = tok_ff ? ST_BAD_HEADER : ST_TRANSPORT_FAIL;
               rsp_time_in   = '0;
               rsp_sync_in   = '0;
               pending_in    = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_time_ff  <= '0;
         ref_cnt_ff   <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ref_time_ff  <= ref_time_in;
         ref_cnt_ff   <= ref_cnt_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      now_ff        <= now_in;
      tok_ff        <= tok_in;
      cset_ff       <= cset_in;
      cid_ff        <= cid_in;
      comp_ff       <= comp_in;
      t0_ff         <= t0_in;
      t1_ff         <= t1_in;
      t2_ff         <= t2_in;
      acc_ff        <= acc_in;
      x_ff          <= x_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_sync_ff   <= rsp_sync_in;
   end

`ifndef SYNTHESIS
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_DIV_ITER && cfg.freq != '0) |-> (rem_ff < cfg.freq))
      else $error("divider remainder reached the divisor");

   a_accepted_matches_ref: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_ACCEPTED) |->
      (ref_time_ff == rsp_time_ff && ref_cnt_ff == rsp_sync_ff))
      else $error("accepted result does not match the stored reference");

   a_request_arms_pending: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_OUT_REQ && out_free) |=> pending_ff)
      else $error("request did not set the read pending flag");

   a_fail_has_zero_time: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_TRANSPORT_FAIL ||
       rsp_status_ff == ST_BAD_HEADER)) |-> (rsp_time_ff == '0 && rsp_sync_ff == '0))
      else $error("rejected response carries a nonzero time");
`endif

endmodule

>>> rtl/core/time_sync_estimator.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  command, counter and header codes, t0 t1 t2
// rsp_      out        rsp_valid/rsp_stall  status, time_ms, sync_counter
// csr_      in         csr_valid/csr_ready  csr_index, csr_data
//
// One item at a time: req_stall is high until the sequencer is back at its load step. A failed
// response goes straight out; otherwise the elapsed time since the reference is scaled by 1000
// and bit-serially divided by the frequency unless it is zero; a good response adds the offset.
// Reset is synchronous and clears the reference, the pending flag, rsp_valid and the CSRs.
// A waiting result does not block the next item; only the final step waits on rsp_stall.
module time_sync_estimator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic [tse_pkg::TIME_W-1:0]          req_counter_now,
   input  logic                                req_transport_ok,
   input  logic [tse_pkg::CODE_W-1:0]          req_resp_command_set,
   input  logic [tse_pkg::CODE_W-1:0]          req_resp_command_id,
   input  logic [tse_pkg::CODE_W-1:0]          req_resp_completion,
   input  logic [tse_pkg::TIME_W-1:0]          req_echoed_send_time,
   input  logic [tse_pkg::TIME_W-1:0]          req_partner_receive_time,
   input  logic [tse_pkg::TIME_W-1:0]          req_partner_reply_time,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tse_pkg::STATUS_W-1:0]        rsp_status,
   output logic [tse_pkg::TIME_W-1:0]          rsp_time_ms,
   output logic [tse_pkg::TIME_W-1:0]          rsp_sync_counter,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tse_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tse_pkg::CSR_DAT_W-1:0]       csr_data
);
   import tse_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   ctrl_word_type ctrl;
   dp_flags_type  flags;
   logic          req_accept;

   assign csr_ready  = 1'b1;
   assign req_stall  = ctrl.op != OP_LOAD;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_FREQ:       cfg_in.freq       = csr_data[FREQ_W-1:0];
            CSR_CMD_SET:    cfg_in.cmd_set    = csr_data[CODE_W-1:0];
            CSR_CMD_ID:     cfg_in.cmd_id     = csr_data[CODE_W-1:0];
            CSR_COMPLETION: cfg_in.completion = csr_data[CODE_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tse_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .flags      (flags),
      .ctrl       (ctrl)
   );

   tse_dp u_dp (
      .clock                    (clock),
      .reset                    (reset),
      .ctrl                     (ctrl),
      .cfg                      (cfg_ff),
      .req_accept               (req_accept),
      .req_command              (req_command),
      .req_counter_now          (req_counter_now),
      .req_transport_ok         (req_transport_ok),
      .req_resp_command_set     (req_resp_command_set),
      .req_resp_command_id      (req_resp_command_id),
      .req_resp_completion      (req_resp_completion),
      .req_echoed_send_time     (req_echoed_send_time),
      .req_partner_receive_time (req_partner_receive_time),
      .req_partner_reply_time   (req_partner_reply_time),
      .rsp_stall                (rsp_stall),
      .rsp_valid                (rsp_valid),
      .rsp_status               (rsp_status),
      .rsp_time_ms              (rsp_time_ms),
      .rsp_sync_counter         (rsp_sync_counter),
      .flags                    (flags)
   );

endmodule
